FILE: src/csd_pkg.sv
// Shared types and constants for the cross-stencil star detector.
// Used by csd_front, csd_back and the top level; depends on nothing.
`default_nettype none

package csd_pkg;

  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int MAX_ROWS       = 4096;
  localparam int QUEUE_DEPTH    = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int THR_W      = 19;
  localparam int ROW_W      = 12;
  localparam int OUT_COL_W  = 10;

  localparam logic [FW_W-1:0]  RST_FRAME_WIDTH    = FW_W'(50);
  localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT   = FH_W'(50);
  localparam logic [THR_W-1:0] RST_STAR_THRESHOLD = THR_W'(30);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_STAR_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                  we;
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic has_prev;
    logic star_ok;
    logic last_row;
    logic last_col;
  } item_flags_t;

endpackage

`default_nettype wire

FILE: src/csd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module csd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/csd_fifo.sv
// Short register queue between the front and back parts.
// No dependencies.
`default_nettype none

module csd_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic      [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/csd_front.sv
// Front part: accepts pixels, tracks row and column, classifies each pixel.
// Depends on csd_pkg; feeds the queue toward csd_back.
`default_nettype none

module csd_front
  import csd_pkg::*;
#(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  localparam int COL_W     = $clog2(MAX_COLS),
  localparam int IW        = PIXEL_BITS + ROW_W + 2 * COL_W + $bits(item_flags_t)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cfg_wr_t               cfg_i,
  input  wire logic [PIXEL_BITS-1:0] pixel_light_i,
  input  wire logic                  pixel_valid_i,
  output logic                       pixel_ready_o,
  output logic                       push_valid_o,
  input  wire logic                  push_ready_i,
  output logic      [IW-1:0]         push_data_o
);

  logic [FW_W-1:0]  width_q, width_d;
  logic [FH_W-1:0]  height_q, height_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] w_m1, rd_addr;
  logic [ROW_W-1:0] h_m1;
  logic [COL_W:0]   col_p2;
  logic             restart, accept;
  item_flags_t      flags;

  assign pixel_ready_o = push_ready_i;
  assign push_valid_o  = pixel_valid_i;
  assign accept        = pixel_valid_i & push_ready_i;

  always_comb begin
    if (32'(width_q) < 32'd2) begin
      w_m1 = COL_W'(1);
    end else if (32'(width_q) > 32'(MAX_COLS)) begin
      w_m1 = COL_W'(MAX_COLS - 1);
    end else begin
      w_m1 = COL_W'(32'(width_q) - 32'd1);
    end
    if (32'(height_q) < 32'd2) begin
      h_m1 = ROW_W'(1);
    end else if (32'(height_q) > 32'(MAX_ROWS)) begin
      h_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      h_m1 = ROW_W'(32'(height_q) - 32'd1);
    end
  end

  // prefetch address: two columns ahead, wrapping into the next row
  always_comb begin
    col_p2 = {1'b0, col_q} + (COL_W + 1)'(2);
    if (col_p2 > {1'b0, w_m1}) begin
      rd_addr = COL_W'(col_p2 - {1'b0, w_m1} - (COL_W + 1)'(1));
    end else begin
      rd_addr = COL_W'(col_p2);
    end
  end

  always_comb begin
    flags.has_prev = (row_q != '0);
    flags.star_ok  = (row_q > ROW_W'(1)) && (col_q != '0) && (col_q != w_m1);
    flags.last_row = (row_q == h_m1);
    flags.last_col = (col_q == w_m1);
  end

  assign push_data_o = {pixel_light_i, row_q, col_q, rd_addr, flags};

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    row_d    = row_q;
    col_d    = col_q;
    restart  = 1'b0;
    if (cfg_i.we) begin
      case (cfg_i.idx)
        CFG_FRAME_WIDTH: begin
          width_d = FW_W'(cfg_i.data);
          restart = 1'b1;
        end
        CFG_FRAME_HEIGHT: begin
          height_d = FH_W'(cfg_i.data);
          restart  = 1'b1;
        end
        CFG_STAR_THRESHOLD: begin
          restart = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
    if (restart) begin
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (col_q == w_m1) begin
        col_d = '0;
        row_d = (row_q == h_m1) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_FRAME_WIDTH;
      height_q <= RST_FRAME_HEIGHT;
      row_q    <= '0;
      col_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      row_q    <= row_d;
      col_q    <= col_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/csd_back.sv
// Back part: line store, sliding column window, stencil sum, result buffer.
// Depends on csd_pkg and csd_ram; takes classified pixels from the queue.
`default_nettype none

module csd_back
  import csd_pkg::*;
#(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  localparam int COL_W     = $clog2(MAX_COLS),
  localparam int IW        = PIXEL_BITS + ROW_W + 2 * COL_W + $bits(item_flags_t)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfg_wr_t              cfg_i,
  input  wire logic                 pop_valid_i,
  output logic                      pop_ready_o,
  input  wire logic [IW-1:0]        pop_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [ROW_W-1:0]     out_row_o,
  output logic      [OUT_COL_W-1:0] out_col_o,
  output logic                      is_star_o,
  output logic                      frame_last_o
);

  localparam int P     = PIXEL_BITS;
  localparam int SUM_W = PIXEL_BITS + 3;
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  // line store word: newer row in the upper half, older row in the lower half
  logic [P-1:0]     in_pix;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col, in_rd_addr;
  item_flags_t      in_flags;

  logic [2*P-1:0]   ram_rdata, win1, wr_data;
  logic [2*P-1:0]   win0_q, fwd_data_q;
  logic             fwd_q;
  logic [P-1:0]     left_q;
  logic             pop;

  logic             s1_valid_q, s1_valid_d, s1_adv;
  logic [P-1:0]     s1_pix_q, s1_up_q, s1_up2_q, s1_left_q, s1_right_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [COL_W-1:0] s1_col_q;
  item_flags_t      s1_flags_q;

  logic [THR_W-1:0] thr_q;
  logic [SUM_W-1:0] sum;
  logic             star;

  logic             a_valid_q, a_valid_d, b_valid_q, b_valid_d, obuf_free, out_take;
  logic [ROW_W-1:0] a_row_q, b_row_q;
  logic [COL_W-1:0] o_col_q;
  logic             a_star_q, b_last_q;

  assign {in_pix, in_row, in_col, in_rd_addr, in_flags} = pop_data_i;

  assign pop_ready_o = !s1_valid_q || s1_adv;
  assign pop         = pop_valid_i & pop_ready_o;
  assign win1        = fwd_q ? fwd_data_q : ram_rdata;
  assign wr_data     = {in_pix, win0_q[2*P-1:P]};

  csd_ram #(
    .WIDTH (2 * P),
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (pop),
    .waddr_i (in_col),
    .wdata_i (wr_data),
    .re_i    (pop),
    .raddr_i (in_rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= RST_STAR_THRESHOLD;
    end else if (cfg_i.we && (cfg_i.idx == CFG_STAR_THRESHOLD)) begin
      thr_q <= THR_W'(cfg_i.data);
    end
  end

  // advance the column window and capture stencil operands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (pop) begin
      fwd_q <= (in_rd_addr == in_col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      fwd_data_q <= wr_data;
      win0_q     <= win1;
      left_q     <= win0_q[2*P-1:P];
      s1_pix_q   <= in_pix;
      s1_up_q    <= win0_q[2*P-1:P];
      s1_up2_q   <= win0_q[P-1:0];
      s1_left_q  <= left_q;
      s1_right_q <= win1[2*P-1:P];
      s1_row_q   <= in_row;
      s1_col_q   <= in_col;
      s1_flags_q <= in_flags;
    end
  end

  assign sum = SUM_W'(s1_pix_q) + SUM_W'(s1_up_q) + SUM_W'(s1_up2_q)
             + SUM_W'(s1_left_q) + SUM_W'(s1_right_q);
  assign star = s1_flags_q.star_ok && (CMP_W'(sum) > CMP_W'(thr_q));

  assign out_take  = out_valid_o & out_ready_i;
  assign obuf_free = (!a_valid_q && !b_valid_q) || (out_ready_i && (a_valid_q ^ b_valid_q));
  assign s1_adv    = s1_valid_q && obuf_free;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    a_valid_d = a_valid_q;
    b_valid_d = b_valid_q;
    if (s1_adv) begin
      a_valid_d = s1_flags_q.has_prev;
      b_valid_d = s1_flags_q.last_row;
    end else if (out_take) begin
      if (a_valid_q) begin
        a_valid_d = 1'b0;
      end else begin
        b_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      a_valid_q  <= 1'b0;
      b_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      a_valid_q  <= a_valid_d;
      b_valid_q  <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      a_row_q  <= s1_row_q - ROW_W'(1);
      b_row_q  <= s1_row_q;
      o_col_q  <= s1_col_q;
      a_star_q <= star;
      b_last_q <= s1_flags_q.last_col;
    end
  end

  assign out_valid_o  = a_valid_q | b_valid_q;
  assign out_row_o    = a_valid_q ? a_row_q : b_row_q;
  assign out_col_o    = OUT_COL_W'(o_col_q);
  assign is_star_o    = a_valid_q & a_star_q;
  assign frame_last_o = !a_valid_q & b_last_q;

endmodule

`default_nettype wire

FILE: src/cross_stencil_star_detect_unit.sv
// Cross-stencil star detector, top level: front, queue and back parts.
// Depends on csd_pkg, csd_front, csd_fifo, csd_back.
// Takes one pixel per clock in raster order while the queue has room and
// reports, one row late, whether each pixel's plus-shaped neighborhood sum
// exceeds the threshold. On the final row each pixel yields two results, so
// there the output port sets the pace. The line store is one RAM of MAX_COLS
// words, each holding the two rows above one column, read two columns ahead
// and written once per pixel. A register write restarts the frame at row 0,
// column 0 and must only happen while the block is idle.
`default_nettype none

module cross_stencil_star_detect_unit
  import csd_pkg::*;
#(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [PIXEL_BITS-1:0] pixel_light_i,
  input  wire logic                  pixel_valid_i,
  output logic                       pixel_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [ROW_W-1:0]      out_row_o,
  output logic      [OUT_COL_W-1:0]  out_col_o,
  output logic                       is_star_o,
  output logic                       frame_last_o
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int IW    = PIXEL_BITS + ROW_W + 2 * COL_W + $bits(item_flags_t);

  cfg_wr_t       cfg;
  logic          q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  logic [IW-1:0] q_push_data, q_pop_data;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_e'(cfg_idx_i);
  assign cfg.data = cfg_data_i;

  csd_front #(
    .MAX_COLS   (MAX_COLS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .pixel_light_i (pixel_light_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .push_valid_o  (q_push_valid),
    .push_ready_i  (q_push_ready),
    .push_data_o   (q_push_data)
  );

  csd_fifo #(
    .WIDTH (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  csd_back #(
    .MAX_COLS   (MAX_COLS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .pop_valid_i  (q_pop_valid),
    .pop_ready_o  (q_pop_ready),
    .pop_data_i   (q_pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .is_star_o    (is_star_o),
    .frame_last_o (frame_last_o)
  );

endmodule

`default_nettype wire
